FILE: design/hbenv_pkg.sv
// Package for the heartbeat envelope generator: types, field widths,
// register indexes and register reset values shared by the design.
// No dependencies.
package hbenv_pkg;

  // Field widths of the keyframe registers and of the result.
  localparam int FRAME_W  = 24;
  localparam int LEVEL_W  = 8;
  localparam int DUR_W    = 16;
  localparam int PERIOD_W = 16;
  localparam int PHASE_W  = 3;
  localparam int PROD_W   = DUR_W + LEVEL_W;
  localparam int CFG_IDX_W = 3;

  // Phase code shown while resting between beats or while disabled.
  localparam logic [PHASE_W-1:0] REST_PHASE = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd4;

  // Register reset values.
  localparam logic [FRAME_W-1:0]  STEP0_RESET  = 24'hFF0064;
  localparam logic [FRAME_W-1:0]  STEP1_RESET  = 24'h000050;
  localparam logic [FRAME_W-1:0]  STEP2_RESET  = 24'hC80050;
  localparam logic [FRAME_W-1:0]  STEP3_RESET  = 24'h000096;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SKIP = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_OUT  = 6'b100000
  } hbenv_state_t;

endpackage

FILE: design/heartbeat_envelope_generator_core.sv
// Heartbeat envelope generator: keyframe sequencer with a bit-serial
// multiplier and a bit-serial divider for the linear interpolation.
// Depends on hbenv_pkg.
//
// Timing: an enable item, or an update while disabled, goes straight to the output
// step and raises m_tvalid once the output register is loaded; an update that
// interpolates skips elapsed keyframes at one per cycle, sets up, multiplies and
// divides at one bit per cycle, finishes and then loads the output register;
// a resting update skips the remaining keyframes and then loads the output register.
// Throughput: one item at a time; the next transfer is taken once the sequencer is
// back in idle, after the previous result has entered the output register.
// A result held by the receiver stalls the sequencer at its output step.
// Synchronous reset clears the sequencer, envelope and output state, sets the
// keyframe and period registers to their defaults, and needs no sweep.
module heartbeat_envelope_generator_core #(
  parameter int NUM_KEYFRAMES = 4,
  parameter int TIME_BITS     = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [39:0]                       s_tdata,   // now_ms[31:0], enable_request
  input  logic                              s_tuser,   // kind
  // Result stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,   // brightness[7:0], phase[2:0]
  output logic                              m_tuser,   // driven
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [hbenv_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [hbenv_pkg::FRAME_W-1:0]     cfg_wdata
);

  import hbenv_pkg::*;

  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(NUM_KEYFRAMES);

  hbenv_state_t state;

  // Configuration registers.
  logic [FRAME_W-1:0]   step_frame [4];
  logic [PERIOD_W-1:0]  beat_interval;

  // Envelope state.
  logic                 enabled;
  logic                 beat_running;
  logic [PHASE_W-1:0]   step_index;
  logic [TIME_BITS-1:0] step_start_time;
  logic [TIME_BITS-1:0] beat_start_time;
  logic [LEVEL_W-1:0]   start_level;
  logic [LEVEL_W-1:0]   shown_level;
  logic                 res_driven;
  logic [2:0]           bit_cnt;

  // Output register.
  logic [LEVEL_W-1:0]   out_level;
  logic [PHASE_W-1:0]   out_phase;
  logic                 out_driven;

  // Working registers of the serial arithmetic.
  logic [TIME_BITS-1:0] now_time;
  logic                 slope_up;
  logic [PROD_W-1:0]    acc;
  logic [PROD_W-1:0]    mcand;
  logic [LEVEL_W-1:0]   mplier;
  logic [DUR_W-1:0]     rem;
  logic [LEVEL_W-1:0]   quo;

  // Combinational views.
  logic [FRAME_W-1:0]   sel_frame;
  logic [LEVEL_W-1:0]   sel_level;
  logic [DUR_W-1:0]     sel_dur;
  logic [TIME_BITS-1:0] step_elapsed;
  logic [TIME_BITS-1:0] beat_elapsed;
  logic                 in_frames;
  logic [DUR_W:0]       div_cand;
  logic                 div_fit;
  logic [LEVEL_W-1:0]   quo_ceil;
  logic                 accept;
  logic                 out_free;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Current keyframe and time differences.
  always_comb begin
    sel_frame    = step_frame[step_index[1:0]];
    sel_level    = sel_frame[FRAME_W-1:DUR_W];
    sel_dur      = sel_frame[DUR_W-1:0];
    step_elapsed = now_time - step_start_time;
    beat_elapsed = now_time - beat_start_time;
    in_frames    = (step_index < LAST_PHASE);
  end

  // One restoring division step: bring down the next numerator bit.
  always_comb begin
    div_cand = {rem, quo[LEVEL_W-1]};
    div_fit  = (div_cand >= {1'b0, sel_dur});
    quo_ceil = quo + LEVEL_W'(rem != '0);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_frame[0]  <= STEP0_RESET;
      step_frame[1]  <= STEP1_RESET;
      step_frame[2]  <= STEP2_RESET;
      step_frame[3]  <= STEP3_RESET;
      beat_interval  <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_STEP0:  step_frame[0]  <= cfg_wdata;
        CFG_STEP1:  step_frame[1]  <= cfg_wdata;
        CFG_STEP2:  step_frame[2]  <= cfg_wdata;
        CFG_STEP3:  step_frame[3]  <= cfg_wdata;
        CFG_PERIOD: beat_interval  <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and envelope state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      enabled         <= 1'b0;
      beat_running    <= 1'b0;
      step_index      <= REST_PHASE;
      step_start_time <= '0;
      beat_start_time <= '0;
      start_level     <= '0;
      shown_level     <= '0;
      res_driven      <= 1'b0;
      bit_cnt         <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser) begin
              // Enable change; only a disable marks the result as driven.
              state <= ST_OUT;
              if (s_tdata[32] != enabled) begin
                enabled <= s_tdata[32];
              end
              if (enabled && !s_tdata[32]) begin
                shown_level  <= '0;
                step_index   <= REST_PHASE;
                beat_running <= 1'b0;
                res_driven   <= 1'b1;
              end else begin
                res_driven <= 1'b0;
              end
            end else if (enabled) begin
              // Update: open a new beat if none is running.
              if (!beat_running) begin
                beat_running    <= 1'b1;
                beat_start_time <= s_tdata[TIME_BITS-1:0];
                step_start_time <= s_tdata[TIME_BITS-1:0];
                step_index      <= '0;
                start_level     <= '0;
              end
              res_driven <= 1'b0;
              state      <= ST_SKIP;
            end else begin
              // Update while disabled leaves the envelope state as it is.
              res_driven <= 1'b0;
              state      <= ST_OUT;
            end
          end
        end
        ST_SKIP: begin
          // Skip one elapsed keyframe per cycle, start the interpolation, or rest after the last keyframe.
          if (in_frames) begin
            if (step_elapsed < TIME_BITS'(sel_dur)) begin
              bit_cnt <= '0;
              state   <= ST_MUL;
            end else begin
              start_level     <= sel_level;
              step_start_time <= step_start_time + TIME_BITS'(sel_dur);
              step_index      <= step_index + 1'b1;
            end
          end else begin
            step_index  <= REST_PHASE;
            shown_level <= '0;
            res_driven  <= 1'b1;
            if (beat_elapsed >= TIME_BITS'(beat_interval)) begin
              beat_running <= 1'b0;
            end
            state <= ST_OUT;
          end
        end
        ST_MUL: begin
          // The counter wraps back to zero on the last multiply cycle.
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == 3'd7) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == 3'd7) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Both slopes round the level down: the fall is rounded up before subtracting.
          if (slope_up) begin
            shown_level <= start_level + quo;
          end else begin
            shown_level <= start_level - quo_ceil;
          end
          res_driven <= 1'b1;
          state      <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: loaded when the result is ready and the previous one has gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      out_level  <= '0;
      out_phase  <= REST_PHASE;
      out_driven <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid   <= 1'b1;
      out_level  <= shown_level;
      out_phase  <= step_index;
      out_driven <= res_driven;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Serial datapath: shift-add multiply, then restoring divide.
  always_ff @(posedge clk) begin
    if (accept) begin
      now_time <= s_tdata[TIME_BITS-1:0];
    end
    case (state)
      ST_SKIP: begin
        // The product width covers the elapsed time, which is below the duration.
        slope_up <= (sel_level >= start_level);
        mplier   <= (sel_level >= start_level) ? (sel_level - start_level)
                                               : (start_level - sel_level);
        mcand    <= PROD_W'(step_elapsed[DUR_W-1:0]);
        acc      <= '0;
      end
      ST_MUL: begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[LEVEL_W-1:1]};
        // The upper part of the product is already below the duration.
        if (bit_cnt == 3'd7) begin
          rem <= mplier[0] ? (acc[PROD_W-1:LEVEL_W] + mcand[PROD_W-1:LEVEL_W]
                              + DUR_W'({1'b0, acc[LEVEL_W-1:0]} + {1'b0, mcand[LEVEL_W-1:0]}
                              >> LEVEL_W))
                           : acc[PROD_W-1:LEVEL_W];
          quo <= mplier[0] ? (acc[LEVEL_W-1:0] + mcand[LEVEL_W-1:0]) : acc[LEVEL_W-1:0];
        end
      end
      ST_DIV: begin
        if (div_fit) begin
          rem <= DUR_W'(div_cand - {1'b0, sel_dur});
        end else begin
          rem <= div_cand[DUR_W-1:0];
        end
        quo <= {quo[LEVEL_W-2:0], div_fit};
      end
      default: ;
    endcase
  end

  // Result fields from the output register.
  assign m_tdata = {5'b0, out_phase, out_level};
  assign m_tuser = out_driven;

  // While idle the phase is a real keyframe or the resting code.
  a_phase_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (step_index < LAST_PHASE || step_index == REST_PHASE))
    else $error("phase out of range while idle");

  // A disabled block has no beat running, shows zero and rests.
  a_disabled_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !enabled) |->
      (!beat_running && shown_level == '0 && step_index == REST_PHASE))
    else $error("disabled block holds beat state");

  // An accepted item always moves the sequencer out of idle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SKIP || state == ST_OUT))
    else $error("accepted item not taken up");

  // The divider only ever runs on a keyframe with a non-zero duration.
  a_div_dur: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (sel_dur != '0 && in_frames))
    else $error("division on an empty keyframe");

  // A result waiting for the receiver holds steady.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("waiting result changed");

endmodule
